### design/in_place_merge_sorter_top_macros.svh
// assertion macros for the in-place merge sorter checker
// used only by the checker module; no other dependencies
`ifndef IN_PLACE_MERGE_SORTER_TOP_MACROS_SVH
`define IN_PLACE_MERGE_SORTER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IMS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ims checker: same-cycle property failed");

// next-cycle implication, disabled during reset
`define IMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ims checker: next-cycle property failed");

`endif

### design/ims_pkg.sv
// shared constants and types of the in-place merge sorter
// no dependencies
`default_nettype none

package ims_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int VAL_W        = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int SHIFT_W      = 11;

   // start command from the load control to the sort engine
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } ims_cmd_type;

   // status back from the sort engine
   typedef struct packed {
      logic               done;
      logic [SHIFT_W-1:0] shifts;
   } ims_stat_type;

   // one write and one read access to the element store
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [VAL_W-1:0] wdata;
      logic [IDX_W-1:0] raddr;
   } ims_ram_req_type;

endpackage

`default_nettype wire

### design/in_place_merge_sorter_top.sv
// top level of the in-place merge sorter: load, sort and emit control
// depends on ims_pkg, ims_ram and ims_engine
//
// usage
//   req channel: one signed 32-bit value per transaction, req_last closes the set.
//   loading takes one transaction per cycle; req_ready is high only while loading.
//   up to MAX_ELEMENTS (64) values are kept; later ones are dropped and rsp_overflow
//   is set on every result of that set. the transaction with req_last still ends it.
//   after the last transaction the set is sorted in place in the element store by a
//   bottom-up merge that rotates out-of-place elements one single shift per cycle.
//   sort time is set by the single store port and the shared comparator and grows
//   with the number of compares, shifts and placements; a full, reversed set of 64
//   takes one shift per inversion.
//   rsp channel: one transaction per element, ascending, with its position; the final
//   one has rsp_end_of_run high and rsp_shift_count equal to the inversion count.
//   each result passes through the read, load and hold states; a stall holds the
//   result in the output register until rsp_ready is seen.
//   after the final result the block is ready for a new set the next cycle.
//   reset (synchronous) empties the set and returns to loading; store contents are
//   left as they are and only entries written in the current set are ever read.
`default_nettype none

module in_place_merge_sorter_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [ims_pkg::VAL_W-1:0] req_value,
   input  wire logic                           req_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [ims_pkg::VAL_W-1:0]    rsp_sorted_value,
   output logic [ims_pkg::IDX_W-1:0]           rsp_position,
   output logic [ims_pkg::SHIFT_W-1:0]         rsp_shift_count,
   output logic                                rsp_overflow,
   output logic                                rsp_end_of_run
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_SORT,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_HOLD
   } state_type;

   state_type state_ff, state_in;

   logic [ims_pkg::CNT_W-1:0]   count_ff, count_in;   // elements in the set
   logic                        ovf_ff, ovf_in;       // dropped values in this set
   logic [ims_pkg::CNT_W-1:0]   pos_ff, pos_in;       // next position to emit
   logic [ims_pkg::SHIFT_W-1:0] total_ff, total_in;   // shift total of the sort

   // output register
   logic                        vld_ff, vld_in;
   logic [ims_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [ims_pkg::IDX_W-1:0]   opos_ff, opos_in;
   logic [ims_pkg::SHIFT_W-1:0] ocnt_ff, ocnt_in;
   logic                        oovf_ff, oovf_in;
   logic                        oend_ff, oend_in;

   logic                      req_fire;
   logic                      has_room;
   logic                      is_end;
   ims_pkg::ims_cmd_type      eng_cmd;
   ims_pkg::ims_stat_type     eng_stat;
   ims_pkg::ims_ram_req_type  eng_ram;
   ims_pkg::ims_ram_req_type  ram_req;
   logic [ims_pkg::VAL_W-1:0] ram_rdata;

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign has_room  = count_ff < ims_pkg::CNT_W'(ims_pkg::MAX_ELEMENTS);
   assign is_end    = (pos_ff + 1'b1) == count_ff;

   // sort starts on the closing transaction with the count including it when it is kept
   assign eng_cmd.start = req_fire && req_last;
   assign eng_cmd.count = has_room ? count_ff + 1'b1 : count_ff;

   ims_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (eng_cmd),
      .stat      (eng_stat),
      .ram_req   (eng_ram),
      .ram_rdata (ram_rdata)
   );

   // store port: engine while sorting, load writes and emit reads otherwise
   always_comb begin
      if (state_ff == S_SORT) begin
         ram_req = eng_ram;
      end else begin
         ram_req.we    = req_fire && has_room;
         ram_req.waddr = count_ff[ims_pkg::IDX_W-1:0];
         ram_req.wdata = req_value;
         ram_req.raddr = pos_ff[ims_pkg::IDX_W-1:0];
      end
   end

   ims_ram #(
      .WIDTH (ims_pkg::VAL_W),
      .DEPTH (ims_pkg::MAX_ELEMENTS)
   ) u_store (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      vld_in   = vld_ff;
      val_in   = val_ff;
      opos_in  = opos_ff;
      ocnt_in  = ocnt_ff;
      oovf_in  = oovf_ff;
      oend_in  = oend_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = S_SORT;
               end
            end
         end
         S_SORT: begin
            if (eng_stat.done) begin
               total_in = eng_stat.shifts;
               pos_in   = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            // read address is pos_ff this cycle
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            vld_in   = 1'b1;
            val_in   = ram_rdata;
            opos_in  = pos_ff[ims_pkg::IDX_W-1:0];
            ocnt_in  = is_end ? total_ff : '0;
            oovf_in  = ovf_ff;
            oend_in  = is_end;
            state_in = S_EMIT_HOLD;
         end
         S_EMIT_HOLD: begin
            if (rsp_ready) begin
               vld_in = 1'b0;
               if (oend_ff) begin
                  // set done, back to loading
                  count_in = '0;
                  ovf_in   = 1'b0;
                  total_in = '0;
                  state_in = S_LOAD;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
         total_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
         vld_ff   <= vld_in;
      end
      val_ff  <= val_in;
      opos_ff <= opos_in;
      ocnt_ff <= ocnt_in;
      oovf_ff <= oovf_in;
      oend_ff <= oend_in;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_sorted_value = val_ff;
   assign rsp_position     = opos_ff;
   assign rsp_shift_count  = ocnt_ff;
   assign rsp_overflow     = oovf_ff;
   assign rsp_end_of_run   = oend_ff;

endmodule

`default_nettype wire

### design/ims_ram.sv
// generic single-write single-read ram with registered read data
// no dependencies
`default_nettype none

module ims_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### design/ims_engine.sv
// bottom-up in-place merge sort sequencer around one shared signed comparator
// depends on ims_pkg; drives the element store through an ims_ram_req_type
`default_nettype none

module ims_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ims_pkg::ims_cmd_type         cmd,
   output ims_pkg::ims_stat_type             stat,
   output ims_pkg::ims_ram_req_type          ram_req,
   input  wire logic [ims_pkg::VAL_W-1:0]    ram_rdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_SKIP_A,
      S_SKIP_B,
      S_LOAD_A,
      S_LOAD_B,
      S_CMP,
      S_SHIFT,
      S_PLACE
   } state_type;

   state_type state_ff, state_in;

   logic [ims_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [ims_pkg::CNT_W-1:0]   w_ff, w_in;
   logic [ims_pkg::CNT_W-1:0]   lo_ff, lo_in;
   logic [ims_pkg::CNT_W-1:0]   a_ff, a_in;
   logic [ims_pkg::CNT_W-1:0]   mid_ff, mid_in;
   logic [ims_pkg::CNT_W-1:0]   b_ff, b_in;
   logic [ims_pkg::CNT_W-1:0]   hi_ff, hi_in;
   logic [ims_pkg::CNT_W-1:0]   k_ff, k_in;
   logic [ims_pkg::VAL_W-1:0]   va_ff, va_in;
   logic [ims_pkg::VAL_W-1:0]   vb_ff, vb_in;
   logic [ims_pkg::SHIFT_W-1:0] shifts_ff, shifts_in;
   logic                        done_ff, done_in;

   // range arithmetic; the sums are one bit wider than the indexes
   logic [ims_pkg::CNT_W:0]   lo_w;
   logic [ims_pkg::CNT_W:0]   lo_2w;
   logic [ims_pkg::CNT_W:0]   hi_cand;
   logic [ims_pkg::CNT_W:0]   w_dbl;
   logic [ims_pkg::CNT_W-1:0] last_idx;
   logic [ims_pkg::CNT_W-1:0] hi_sel;

   // the shared comparator
   logic [ims_pkg::VAL_W-1:0] cmp_b;
   logic                      cmp_le;

   assign lo_w     = {1'b0, lo_ff} + {1'b0, w_ff};
   assign lo_2w    = lo_w + {1'b0, w_ff};
   assign hi_cand  = lo_2w - 1'b1;
   assign w_dbl    = {w_ff, 1'b0};
   assign last_idx = n_ff - 1'b1;
   assign hi_sel   = (hi_cand > {1'b0, last_idx}) ? last_idx : hi_cand[ims_pkg::CNT_W-1:0];

   assign cmp_b  = (state_ff == S_SKIP_B) ? ram_rdata : vb_ff;
   assign cmp_le = $signed(va_ff) <= $signed(cmp_b);

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      w_in      = w_ff;
      lo_in     = lo_ff;
      a_in      = a_ff;
      mid_in    = mid_ff;
      b_in      = b_ff;
      hi_in     = hi_ff;
      k_in      = k_ff;
      va_in     = va_ff;
      vb_in     = vb_ff;
      shifts_in = shifts_ff;
      done_in   = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.waddr = k_ff[ims_pkg::IDX_W-1:0];
      ram_req.wdata = ram_rdata;
      ram_req.raddr = a_ff[ims_pkg::IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               n_in      = cmd.count;
               w_in      = ims_pkg::CNT_W'(1);
               lo_in     = '0;
               shifts_in = '0;
               if (cmd.count <= ims_pkg::CNT_W'(1)) begin
                  done_in = 1'b1;
               end else begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            if (lo_w >= {1'b0, n_ff}) begin
               // pass finished
               if (w_dbl >= {1'b0, n_ff}) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  w_in  = w_dbl[ims_pkg::CNT_W-1:0];
                  lo_in = '0;
               end
            end else begin
               a_in          = lo_ff;
               mid_in        = lo_w[ims_pkg::CNT_W-1:0] - 1'b1;
               b_in          = lo_w[ims_pkg::CNT_W-1:0];
               hi_in         = hi_sel;
               ram_req.raddr = lo_w[ims_pkg::IDX_W-1:0] - 1'b1;
               state_in      = S_SKIP_A;
            end
         end
         S_SKIP_A: begin
            va_in         = ram_rdata;
            ram_req.raddr = b_ff[ims_pkg::IDX_W-1:0];
            state_in      = S_SKIP_B;
         end
         S_SKIP_B: begin
            if (cmp_le) begin
               // halves already in order
               lo_in    = lo_2w[ims_pkg::CNT_W-1:0];
               state_in = S_SETUP;
            end else begin
               vb_in         = ram_rdata;
               ram_req.raddr = a_ff[ims_pkg::IDX_W-1:0];
               state_in      = S_LOAD_A;
            end
         end
         S_LOAD_A: begin
            va_in    = ram_rdata;
            state_in = S_CMP;
         end
         S_LOAD_B: begin
            vb_in    = ram_rdata;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (cmp_le) begin
               if (a_ff >= mid_ff) begin
                  lo_in    = lo_2w[ims_pkg::CNT_W-1:0];
                  state_in = S_SETUP;
               end else begin
                  a_in          = a_ff + 1'b1;
                  ram_req.raddr = a_ff[ims_pkg::IDX_W-1:0] + 1'b1;
                  state_in      = S_LOAD_A;
               end
            end else begin
               // right element moves left: fetch its left neighbor first
               k_in          = b_ff;
               ram_req.raddr = b_ff[ims_pkg::IDX_W-1:0] - 1'b1;
               state_in      = S_SHIFT;
            end
         end
         S_SHIFT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = k_ff[ims_pkg::IDX_W-1:0];
            ram_req.wdata = ram_rdata;
            shifts_in     = shifts_ff + 1'b1;
            if (k_ff - 1'b1 == a_ff) begin
               state_in = S_PLACE;
            end else begin
               k_in          = k_ff - 1'b1;
               ram_req.raddr = k_ff[ims_pkg::IDX_W-1:0] - 2'd2;
            end
         end
         S_PLACE: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = a_ff[ims_pkg::IDX_W-1:0];
            ram_req.wdata = vb_ff;
            a_in          = a_ff + 1'b1;
            mid_in        = mid_ff + 1'b1;
            b_in          = b_ff + 1'b1;
            // left value now sits one place right, va_ff still holds it
            if (b_ff >= hi_ff) begin
               lo_in    = lo_2w[ims_pkg::CNT_W-1:0];
               state_in = S_SETUP;
            end else begin
               ram_req.raddr = b_ff[ims_pkg::IDX_W-1:0] + 1'b1;
               state_in      = S_LOAD_B;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         shifts_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         shifts_ff <= shifts_in;
         done_ff   <= done_in;
      end
      n_ff   <= n_in;
      w_ff   <= w_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      mid_ff <= mid_in;
      b_ff   <= b_in;
      hi_ff  <= hi_in;
      k_ff   <= k_in;
      va_ff  <= va_in;
      vb_ff  <= vb_in;
   end

   assign stat.done   = done_ff;
   assign stat.shifts = shifts_ff;

endmodule

`default_nettype wire

### design/ims_checker.sv
// port-level checker for the in-place merge sorter, bound to the top level
// depends on ims_pkg and in_place_merge_sorter_top_macros.svh
`default_nettype none
`include "in_place_merge_sorter_top_macros.svh"

module ims_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           req_last,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [ims_pkg::VAL_W-1:0] rsp_sorted_value,
   input wire logic [ims_pkg::IDX_W-1:0]      rsp_position,
   input wire logic [ims_pkg::SHIFT_W-1:0]    rsp_shift_count,
   input wire logic                           rsp_overflow,
   input wire logic                           rsp_end_of_run
);

   logic req_fire;
   logic rsp_fire;
   logic [ims_pkg::VAL_W+ims_pkg::IDX_W+ims_pkg::SHIFT_W+1:0] rsp_bus;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign rsp_bus  = {rsp_sorted_value, rsp_position, rsp_shift_count, rsp_overflow,
                      rsp_end_of_run};

   // stalled result holds
   `IMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bus))

   // no loading while results are pending
   `IMS_ASSERT_NOW(a_no_load_in_emit, clock, reset, rsp_valid, !req_ready)

   // shift total only on the final result
   `IMS_ASSERT_NOW(a_count_on_end, clock, reset, rsp_fire && !rsp_end_of_run, rsp_shift_count == '0)

   // a closing transaction stops loading until results are out
   `IMS_ASSERT_NEXT(a_last_stops_load, clock, reset, req_fire && req_last, !req_ready)

   // after the final result the block loads again
   `IMS_ASSERT_NEXT(a_end_reload, clock, reset, rsp_fire && rsp_end_of_run, req_ready && !rsp_valid)

endmodule

bind in_place_merge_sorter_top ims_checker u_ims_checker (.*);

`default_nettype wire
